// File: rtl/assert_macros.svh
// assertion macros for the rtl top level, timestamp_lru_replacement
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/tlru_pkg.sv
// types, sizes and codes of the timestamp lru replacement unit
// no dependencies
package tlru_pkg;

  localparam int SETS      = 1024;
  localparam int WAYS      = 16;

  localparam int SET_IDX_W = 10;
  localparam int WAY_IDX_W = 4;
  localparam int STAMP_W   = 64;
  localparam int VICTIM_W  = 4;

  localparam int SET_AW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_AW    = $clog2(WAYS);

  typedef enum logic [0:0] {
    OP_VICTIM = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUSY
  } state_t;

  typedef logic [WAYS-1:0][STAMP_W-1:0] row_t;

  typedef struct packed {
    logic                 en;
    logic                 clr;
    logic [SET_AW-1:0]    set;
    logic [WAY_AW-1:0]    way;
    logic [STAMP_W-1:0]   stamp;
  } mem_wr_t;

endpackage

// File: rtl/tlru_stamp_mem.sv
// stamp memory: one row of way stamps per set, per-way write, row clear
// depends on tlru_pkg
module tlru_stamp_mem (
  input  logic                        clk,
  input  tlru_pkg::mem_wr_t           wr,
  input  logic                        rd_en,
  input  logic [tlru_pkg::SET_AW-1:0] rd_set,
  output tlru_pkg::row_t              rd_row
);
  import tlru_pkg::*;

  row_t mem [SETS];
  row_t rd_row_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.clr) begin
        mem[wr.set] <= '0;
      end else begin
        mem[wr.set][wr.way] <= wr.stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= mem[rd_set];
    end
  end

  assign rd_row = rd_row_r;

endmodule

// File: rtl/tlru_min_tree.sv
// registered minimum tree over the way stamps of one row, lowest way wins ties
// depends on tlru_pkg
module tlru_min_tree (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  tlru_pkg::row_t              row,
  output logic                        out_valid,
  output logic [tlru_pkg::WAY_AW-1:0] out_way
);
  import tlru_pkg::*;

  localparam int LEVELS = WAY_AW;
  localparam int PAD    = 1 << LEVELS;

  // level zero, padded with stamps that never win
  logic [PAD-1:0][STAMP_W-1:0] lvl0_stamp;
  logic [PAD-1:0][WAY_AW-1:0]  lvl0_way;

  // entry l holds tree level l+1
  logic [PAD-1:0][STAMP_W-1:0] lvl_stamp_r [LEVELS];
  logic [PAD-1:0][WAY_AW-1:0]  lvl_way_r   [LEVELS];
  logic [LEVELS-1:0]           vld_r;

  for (genvar i = 0; i < PAD; i++) begin : g_pad
    if (i < WAYS) begin : g_real
      assign lvl0_stamp[i] = row[i];
    end else begin : g_fill
      assign lvl0_stamp[i] = '1;
    end
    assign lvl0_way[i] = WAY_AW'(i);
  end

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    for (genvar i = 0; i < (PAD >> (l + 1)); i++) begin : g_node
      logic [STAMP_W-1:0] a_stamp, b_stamp;
      logic [WAY_AW-1:0]  a_way, b_way;
      if (l == 0) begin : g_src0
        assign a_stamp = lvl0_stamp[2*i];
        assign b_stamp = lvl0_stamp[2*i+1];
        assign a_way   = lvl0_way[2*i];
        assign b_way   = lvl0_way[2*i+1];
      end else begin : g_srcn
        assign a_stamp = lvl_stamp_r[l-1][2*i];
        assign b_stamp = lvl_stamp_r[l-1][2*i+1];
        assign a_way   = lvl_way_r[l-1][2*i];
        assign b_way   = lvl_way_r[l-1][2*i+1];
      end
      // upper way only on strictly smaller stamp
      always_ff @(posedge clk) begin
        if (b_stamp < a_stamp) begin
          lvl_stamp_r[l][i] <= b_stamp;
          lvl_way_r[l][i]   <= b_way;
        end else begin
          lvl_stamp_r[l][i] <= a_stamp;
          lvl_way_r[l][i]   <= a_way;
        end
      end
    end
  end

  if (LEVELS > 1) begin : g_vld_chain
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= '0;
      end else begin
        vld_r <= {vld_r[LEVELS-2:0], in_valid};
      end
    end
  end else begin : g_vld_one
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= '0;
      end else begin
        vld_r <= in_valid;
      end
    end
  end

  assign out_valid = vld_r[LEVELS-1];
  assign out_way   = lvl_way_r[LEVELS-1][0];

endmodule

// File: rtl/timestamp_lru_replacement.sv
// top level of the timestamp lru replacement unit
// depends on tlru_pkg, tlru_stamp_mem, tlru_min_tree and assert_macros.svh
//
//   channel  | handshake          | words
//   ---------+--------------------+----------------------------------------------
//   input    | start & !busy      | in_opcode, in_set_index, in_way_index, in_hit,
//            |                    | in_is_write, in_now
//   result   | out_valid (strobe) | out_victim_way
//
// an update writes its stamp at the accepting edge
// a victim request goes through one memory read, the min tree with one register per
// compare level, and one output register
// the result is shown for one cycle with out_valid; busy is already low then
// after reset every set of the stamp memory is cleared, one set per cycle, with
// busy high
// the receiver cannot stall, so nothing is held back on the result side
`include "assert_macros.svh"

module timestamp_lru_replacement (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_opcode,
  input  logic [tlru_pkg::SET_IDX_W-1:0]   in_set_index,
  input  logic [tlru_pkg::WAY_IDX_W-1:0]   in_way_index,
  input  logic                             in_hit,
  input  logic                             in_is_write,
  input  logic [tlru_pkg::STAMP_W-1:0]     in_now,
  output logic                             out_valid,
  output logic [tlru_pkg::VICTIM_W-1:0]    out_victim_way
);
  import tlru_pkg::*;

  state_t             state_r, state_nxt;
  logic [SET_AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               rd_vld_r;
  logic               req_oor_r;
  logic               out_valid_r;
  logic [VICTIM_W-1:0] out_way_r;

  logic               accept;
  logic               set_ok, way_ok, stamp_ok;
  logic [SET_AW-1:0]  set_addr;
  logic               rd_en;
  mem_wr_t            wr_req;
  row_t               rd_row;
  logic               tree_vld;
  logic [WAY_AW-1:0]  tree_way;

  assign accept   = start && !busy;
  assign set_addr = SET_AW'(in_set_index);
  // updates to out-of-range sets or ways are dropped, writeback hits keep the stamp
  assign set_ok   = 32'(in_set_index) < SETS;
  assign way_ok   = 32'(in_way_index) < WAYS;
  assign stamp_ok = !(in_hit && in_is_write);

  // control: clear sweep, idle, victim in flight
  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    busy         = 1'b1;
    rd_en        = 1'b0;
    wr_req.en    = 1'b0;
    wr_req.clr   = 1'b0;
    wr_req.set   = set_addr;
    wr_req.way   = WAY_AW'(in_way_index);
    wr_req.stamp = in_now;
    unique case (state_r)
      ST_CLEAR: begin
        wr_req.en   = 1'b1;
        wr_req.clr  = 1'b1;
        wr_req.set  = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SET_AW'(SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_opcode == OP_UPDATE) begin
            wr_req.en = set_ok && way_ok && stamp_ok;
          end else begin
            rd_en     = 1'b1;
            state_nxt = ST_BUSY;
          end
        end
      end
      ST_BUSY: begin
        // leave as the tree finishes; the strobe follows in idle
        if (tree_vld) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // read data valid marker into the tree, and the registered result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= rd_en;
      out_valid_r <= tree_vld;
    end
  end

  // request flag and result word, no reset needed
  always_ff @(posedge clk) begin
    if (rd_en) begin
      req_oor_r <= !set_ok;
    end
    if (tree_vld) begin
      out_way_r <= req_oor_r ? '0 : VICTIM_W'(tree_way);
    end
  end

  tlru_stamp_mem u_mem (
    .clk    (clk),
    .wr     (wr_req),
    .rd_en  (rd_en),
    .rd_set (set_addr),
    .rd_row (rd_row)
  );

  tlru_min_tree u_tree (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rd_vld_r),
    .row       (rd_row),
    .out_valid (tree_vld),
    .out_way   (tree_way)
  );

  assign out_valid      = out_valid_r;
  assign out_victim_way = out_way_r;

  // result strobe only ever lands in idle
  `ASSERT_IMPLY(a_strobe_idle, clk, rst_n, out_valid_r, state_r == ST_IDLE)
  // stamp updates only come from accepted items
  `ASSERT_IMPLY(a_upd_idle, clk, rst_n, wr_req.en && !wr_req.clr, accept)
  // a victim request occupies the unit on the next cycle
  `ASSERT_NEXT(a_victim_busy, clk, rst_n, accept && in_opcode == OP_VICTIM,
               state_r == ST_BUSY)
  // tree output only while a victim request is in flight
  `ASSERT_IMPLY(a_tree_busy, clk, rst_n, tree_vld, state_r == ST_BUSY)

endmodule

// File: verif/timestamp_lru_replacement_tb.sv
// testbench for timestamp_lru_replacement: directed and random victim requests and updates,
// checked word by word against a built-in timestamp lru predictor
// depends on tlru_pkg and the rtl of timestamp_lru_replacement
`timescale 1ns / 100ps

module timestamp_lru_replacement_tb;
  import tlru_pkg::*;

  // one input word as the driver holds it
  typedef struct {
    op_t                  opcode;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_IDX_W-1:0] way_index;
    logic                 hit;
    logic                 is_write;
    logic [STAMP_W-1:0]   now;
  } lru_word_t;

  localparam int HOT_SETS = 6;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 start        = 1'b0;
  logic                 busy;
  logic                 in_opcode    = 1'b0;
  logic [SET_IDX_W-1:0] in_set_index = '0;
  logic [WAY_IDX_W-1:0] in_way_index = '0;
  logic                 in_hit       = 1'b0;
  logic                 in_is_write  = 1'b0;
  logic [STAMP_W-1:0]   in_now       = '0;
  logic                 out_valid;
  logic [VICTIM_W-1:0]  out_victim_way;

  // predictor state: last-use stamp of every set and way, zero at the start
  logic [STAMP_W-1:0]   last_use [SETS][WAYS];
  logic [VICTIM_W-1:0]  expected_victims [$];
  lru_word_t            pending_words [$];
  lru_word_t            driven_word;
  int                   accepted_words = 0;
  int                   error_count    = 0;

  timestamp_lru_replacement dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_set_index   (in_set_index),
    .in_way_index   (in_way_index),
    .in_hit         (in_hit),
    .in_is_write    (in_is_write),
    .in_now         (in_now),
    .out_valid      (out_valid),
    .out_victim_way (out_victim_way)
  );

  // 2 ns period
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // oldest stamp in the set, lowest way on a tie; sets past the end answer way 0
  function automatic logic [VICTIM_W-1:0] oldest_way(logic [SET_IDX_W-1:0] set_no);
    int unsigned        best;
    logic [STAMP_W-1:0] best_stamp;
    best = 0;
    if (set_no >= SETS) return '0;
    best_stamp = last_use[set_no][0];
    for (int w = 1; w < WAYS; w++) begin
      if (last_use[set_no][w] < best_stamp) begin
        best_stamp = last_use[set_no][w];
        best       = w;
      end
    end
    return best[VICTIM_W-1:0];
  endfunction

  // one random flag bit
  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  // advance the predictor by one accepted word
  task automatic track_word(input lru_word_t w);
    if (w.opcode == OP_VICTIM) begin
      expected_victims.push_back(oldest_way(w.set_index));
    end else if (w.set_index < SETS && w.way_index < WAYS) begin
      // a writeback hit leaves the stamp alone
      if (!(w.hit && w.is_write)) last_use[w.set_index][w.way_index] = w.now;
    end
  endtask

  task automatic queue_word(input op_t op, input int unsigned set_no, input int unsigned way_no,
                            input logic hit, input logic wr, input logic [STAMP_W-1:0] now);
    lru_word_t w;
    w.opcode    = op;
    w.set_index = set_no[SET_IDX_W-1:0];
    w.way_index = way_no[WAY_IDX_W-1:0];
    w.hit       = hit;
    w.is_write  = wr;
    w.now       = now;
    pending_words.push_back(w);
  endtask

  // driver: a word is taken at an edge where start is high and busy low.
  // a word that is not taken stays on the ports untouched; otherwise the next
  // one goes out unless the sender idles this cycle. sender idle rate by phase:
  // 22 % for the first third, 86 % for the second, none for the rest
  always @(posedge clk) begin
    int idle_pct;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        track_word(driven_word);
        accepted_words++;
      end
      if (!start || !busy) begin
        idle_pct = (accepted_words < 217) ? 22 : (accepted_words < 434) ? 86 : 0;
        if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
          driven_word  = pending_words.pop_front();
          start        <= 1'b1;
          in_opcode    <= driven_word.opcode;
          in_set_index <= driven_word.set_index;
          in_way_index <= driven_word.way_index;
          in_hit       <= driven_word.hit;
          in_is_write  <= driven_word.is_write;
          in_now       <= driven_word.now;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: a result word lives for exactly one cycle under out_valid
  always @(posedge clk) begin
    logic [VICTIM_W-1:0] want;
    if (rst_n && out_valid) begin
      if (expected_victims.size() == 0) begin
        $error("victim_way word with nothing expected, actual %0d", out_victim_way);
        error_count++;
      end else begin
        want = expected_victims.pop_front();
        if (out_victim_way !== want) begin
          $error("victim_way mismatch: expected %0d, actual %0d", want, out_victim_way);
          error_count++;
        end
      end
    end
  end

  // hard stop well past the slowest legal run (clear pass plus ~650 words)
  initial begin
    #500000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned        hot [HOT_SETS];
    int unsigned        order [WAYS];
    int unsigned        set_no;
    int unsigned        j;
    int unsigned        tmp;
    int unsigned        burst;
    int                 total_words;
    logic [STAMP_W-1:0] clock_now;

    for (int s = 0; s < SETS; s++)
      for (int w = 0; w < WAYS; w++) last_use[s][w] = '0;

    // ---- directed part ----
    // fresh sets: every stamp is zero, so the lowest way wins the tie
    queue_word(OP_VICTIM, 0, 0, 1'b0, 1'b0, '0);
    queue_word(OP_VICTIM, SETS - 1, WAYS - 1, 1'b0, 1'b0, '0);
    // largest stamp on way 0, zero stamp on the top way: way 1 becomes oldest
    queue_word(OP_UPDATE, 0, 0, 1'b0, 1'b0, '1);
    queue_word(OP_UPDATE, 0, WAYS - 1, 1'b0, 1'b0, '0);
    queue_word(OP_VICTIM, 0, 0, 1'b0, 1'b0, '0);
    // read hit on the last set, top way
    queue_word(OP_UPDATE, SETS - 1, WAYS - 1, 1'b1, 1'b0, 64'd1);
    queue_word(OP_VICTIM, SETS - 1, 0, 1'b0, 1'b0, '0);
    // writeback hit must not touch the stamp written by the miss before it
    queue_word(OP_UPDATE, 1, 0, 1'b0, 1'b0, 64'd50);
    queue_word(OP_UPDATE, 1, 0, 1'b1, 1'b1, 64'd0);
    queue_word(OP_VICTIM, 1, 0, 1'b0, 1'b0, '0);
    // write miss does update
    queue_word(OP_UPDATE, 1, 1, 1'b0, 1'b1, 64'd7);
    queue_word(OP_VICTIM, 1, 0, 1'b0, 1'b0, '0);
    // victim request with every ignored field set
    queue_word(OP_VICTIM, 1, WAYS - 1, 1'b1, 1'b1, '1);
    // top bit of the stamp alone versus the all-ones stamp
    queue_word(OP_UPDATE, SETS - 1, 0, 1'b1, 1'b0, {1'b1, {(STAMP_W-1){1'b0}}});
    queue_word(OP_UPDATE, SETS - 1, 1, 1'b0, 1'b1, '1);
    queue_word(OP_VICTIM, SETS - 1, 0, 1'b0, 1'b0, '0);

    // ---- random part ----
    // mostly cache-like traffic on a few hot sets with rising stamps,
    // now and then a full fill of a set, the rest random noise and stamps near the top
    hot[0] = 0;
    hot[1] = SETS - 1;
    for (int i = 2; i < HOT_SETS; i++) hot[i] = $urandom_range(SETS - 1);
    clock_now = {2'b00, 30'($urandom), $urandom};

    while (pending_words.size() < 650) begin
      tmp = $urandom_range(99);
      set_no = hot[$urandom_range(HOT_SETS - 1)];
      if (tmp < 12) begin
        // fill every way in random order, then ask for the victim
        for (int w = 0; w < WAYS; w++) order[w] = w;
        for (int w = WAYS - 1; w > 0; w--) begin
          j        = $urandom_range(w);
          tmp      = order[w];
          order[w] = order[j];
          order[j] = tmp;
        end
        for (int w = 0; w < WAYS; w++) begin
          clock_now += 64'($urandom_range(1, 40));
          queue_word(OP_UPDATE, set_no, order[w], rand_bit(), rand_bit(), clock_now);
        end
        queue_word(OP_VICTIM, set_no, $urandom_range(WAYS - 1), rand_bit(), rand_bit(),
                   {$urandom, $urandom});
      end else if (tmp < 80) begin
        // a few touches, then a victim request on the same set
        burst = $urandom_range(1, 4);
        for (int k = 0; k < burst; k++) begin
          clock_now += 64'($urandom_range(0, 60));
          queue_word(OP_UPDATE, set_no, $urandom_range(WAYS - 1), rand_bit(), rand_bit(),
                     clock_now);
        end
        queue_word(OP_VICTIM, set_no, $urandom_range(WAYS - 1), rand_bit(), rand_bit(),
                   {$urandom, $urandom});
      end else if (tmp < 95) begin
        // noise anywhere in the field ranges
        queue_word(op_t'($urandom_range(1)), $urandom_range(SETS - 1), $urandom_range(WAYS - 1),
                   rand_bit(), rand_bit(), {$urandom, $urandom});
      end else begin
        // stamps close to the top of the range
        queue_word(OP_UPDATE, set_no, $urandom_range(WAYS - 1), rand_bit(), rand_bit(),
                   '1 - 64'($urandom_range(15)));
      end
    end
    total_words = pending_words.size();

    // reset held at the start; the block then clears its stamps with busy high
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // all words taken, then all results in, then a further wait past the pipeline depth
    do @(posedge clk); while (accepted_words != total_words);
    while (expected_victims.size() != 0) @(posedge clk);
    repeat (4 * (WAY_AW + 2)) @(posedge clk);

    if (expected_victims.size() != 0) begin
      $error("victim_way words missing: expected %0d more, actual 0", expected_victims.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
